// ----- rtl/cbcm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbcm_pkg
// Shared types, the AES S-box and the AES round helpers for the CBC-MAC unit.
// ----------------------------------------------------------------------------
package cbcm_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
    localparam int IDX_W       = $clog2(BLOCK_BYTES);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY1_HI  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1_LO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_HI = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LO = 3'd5;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // One block for the cipher; byte 0 sits in the top bits.
    typedef struct packed {
        logic [127:0] block;
        logic         last_blk;
        logic         first_blk;
    } cbcm_job_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    // Round key for the next round from the current one.
    function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                    input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows and, unless it is the last round, MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   al;
        for (int c = 0; c < 4; c++)
        begin
            for (int q = 0; q < 4; q++)
            begin
                t[127 - 8*(q + 4*c) -: 8] = SBOX[byte_at(s, q + 4*((c + q) % 4))];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = byte_at(t, 4*c);
            a1 = byte_at(t, 4*c + 1);
            a2 = byte_at(t, 4*c + 2);
            a3 = byte_at(t, 4*c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 32*c -: 8]      = a0 ^ al ^ xt(a0 ^ a1);
            m[127 - 32*c - 8 -: 8]  = a1 ^ al ^ xt(a1 ^ a2);
            m[127 - 32*c - 16 -: 8] = a2 ^ al ^ xt(a2 ^ a3);
            m[127 - 32*c - 24 -: 8] = a3 ^ al ^ xt(a3 ^ a0);
        end
        return last ? t : m;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cbcm_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbcm_fifo
// Two-entry queue of cipher jobs between the byte front end and the AES core.
// ----------------------------------------------------------------------------
module cbcm_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cbcm_pkg::cbcm_job_t push_job,
    output logic                    full,
    input  wire logic               pop,
    output logic                    empty,
    output cbcm_pkg::cbcm_job_t     head
);
    import cbcm_pkg::*;

    cbcm_job_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cbcm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbcm_front
// Collects message bytes into blocks, pads the final block and queues jobs.
// ----------------------------------------------------------------------------
module cbcm_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic               has_byte,
    input  wire logic               end_of_message,
    output logic                    push,
    output cbcm_pkg::cbcm_job_t     push_job,
    input  wire logic               q_full
);
    import cbcm_pkg::*;

    logic [7:0]       blk_reg  [BLOCK_BYTES];
    logic [7:0]       blk_next [BLOCK_BYTES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_msg_reg;
    logic             in_msg_next;
    logic             first_reg;
    logic             first_next;
    logic             pend_reg;
    logic             pend_next;

    function automatic logic [127:0] pack_block(input logic [7:0] b [BLOCK_BYTES]);
        logic [127:0] v;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            v[127 - 8*i -: 8] = b[i];
        end
        return v;
    endfunction

    function automatic logic [127:0] pad_block(input logic [7:0] b [BLOCK_BYTES],
                                               input logic [CNT_W-1:0] n);
        logic [127:0] v;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (CNT_W'(i) < n)
                v[127 - 8*i -: 8] = b[i];
            else if (CNT_W'(i) == n)
                v[127 - 8*i -: 8] = PAD_BYTE;
            else
                v[127 - 8*i -: 8] = ZERO_BYTE;
        end
        return v;
    endfunction

    assign in_ready = !pend_reg && !q_full;

    always_comb
    begin
        logic             first_now;
        logic [CNT_W-1:0] cnt;
        blk_next    = blk_reg;
        count_next  = count_reg;
        in_msg_next = in_msg_reg;
        first_next  = first_reg;
        pend_next   = pend_reg;
        push        = 1'b0;
        push_job    = '{block: pack_block(blk_reg), last_blk: 1'b0, first_blk: 1'b0};
        first_now   = !in_msg_reg || first_reg;
        cnt         = in_msg_reg ? count_reg : '0;
        if (pend_reg)
        begin
            // A full block went out with the end flag's byte; the final block follows.
            if (!q_full)
            begin
                push        = 1'b1;
                push_job    = '{block: pad_block(blk_reg, count_reg), last_blk: 1'b1,
                                first_blk: 1'b0};
                pend_next   = 1'b0;
                count_next  = '0;
                in_msg_next = 1'b0;
            end
        end
        else if (in_valid && in_ready && (has_byte || end_of_message))
        begin
            in_msg_next = 1'b1;
            first_next  = first_now;
            if (has_byte)
            begin
                if (cnt == CNT_W'(BLOCK_BYTES))
                begin
                    push        = 1'b1;
                    push_job    = '{block: pack_block(blk_reg), last_blk: 1'b0,
                                    first_blk: first_now};
                    first_next  = 1'b0;
                    blk_next[0] = data_byte;
                    cnt         = CNT_W'(1);
                end
                else
                begin
                    blk_next[cnt[IDX_W-1:0]] = data_byte;
                    cnt = cnt + CNT_W'(1);
                end
            end
            if (end_of_message)
            begin
                if (push)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    push        = 1'b1;
                    push_job    = '{block: pad_block(blk_next, cnt), last_blk: 1'b1,
                                    first_blk: first_now};
                    cnt         = '0;
                    in_msg_next = 1'b0;
                end
            end
            count_next = cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            in_msg_reg <= 1'b0;
            first_reg  <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            in_msg_reg <= in_msg_next;
            first_reg  <= first_next;
            pend_reg   <= pend_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cbcm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbcm_back
// Iterative AES-128 core, one round per cycle, with the chain and MAC output.
// ----------------------------------------------------------------------------
module cbcm_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire cbcm_pkg::cbcm_job_t job,
    output logic                    pop,
    input  wire logic [127:0]       key_one,
    input  wire logic [127:0]       key_two,
    input  wire logic [127:0]       start_chain,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [63:0]             mac_half,
    output logic                    last_half
);
    import cbcm_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_t;

    state_t       state_reg;
    state_t       state_next;
    logic [127:0] s_reg;
    logic [127:0] s_next;
    logic [127:0] rk_reg;
    logic [127:0] rk_next;
    logic [127:0] chain_reg;
    logic [127:0] chain_next;
    logic [7:0]   rcon_reg;
    logic [7:0]   rcon_next;
    logic [3:0]   round_reg;
    logic [3:0]   round_next;
    logic         last_reg;
    logic         last_next;
    logic         ov_reg;
    logic         ov_next;
    logic         half_reg;
    logic         half_next;
    logic [127:0] mac_reg;
    logic [127:0] mac_next;

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = ov_reg;
    assign last_half = half_reg;
    assign mac_half  = half_reg ? mac_reg[63:0] : mac_reg[127:64];

    always_comb
    begin
        logic [127:0] key;
        logic [127:0] rk_n;
        state_next = state_reg;
        s_next     = s_reg;
        rk_next    = rk_reg;
        chain_next = chain_reg;
        rcon_next  = rcon_reg;
        round_next = round_reg;
        last_next  = last_reg;
        ov_next    = ov_reg;
        half_next  = half_reg;
        mac_next   = mac_reg;
        key        = job.last_blk ? key_two : key_one;
        rk_n       = next_round_key(rk_reg, rcon_reg);

        if (ov_reg && out_ready)
        begin
            if (half_reg)
                ov_next = 1'b0;
            else
                half_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    s_next     = job.block ^ (job.first_blk ? start_chain : chain_reg) ^ key;
                    rk_next    = key;
                    rcon_next  = 8'h01;
                    round_next = 4'd1;
                    last_next  = job.last_blk;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                s_next     = aes_round(s_reg, round_reg == 4'd10) ^ rk_n;
                rk_next    = rk_n;
                rcon_next  = xt(rcon_reg);
                round_next = round_reg + 4'd1;
                if (round_reg == 4'd10)
                begin
                    chain_next = s_next;
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                // The MAC waits here until the previous one has fully left.
                if (!ov_reg)
                begin
                    mac_next   = chain_reg;
                    ov_next    = 1'b1;
                    half_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        rk_reg    <= rk_next;
        rcon_reg  <= rcon_next;
        round_reg <= round_next;
        last_reg  <= last_next;
        mac_reg   <= mac_next;
        chain_reg <= chain_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            half_reg  <= half_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/two_key_cbc_mac_aes128_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// two_key_cbc_mac_aes128_unit
// Two-key AES-128 CBC-MAC over a byte stream.
// ----------------------------------------------------------------------------
// The slave stream takes one message byte per beat (tuser set when the beat
// carries a byte, tlast set on the last beat of a message). The master stream
// returns the 128-bit MAC as two 64-bit beats, bytes 0..7 first; tlast marks
// the second beat. Keys and the start chain are written through the cfg port,
// which is always ready; write it only while no message is in flight.
// Bytes are taken at one per cycle while the job queue has room and no final
// block is pending. Each 16-byte block runs through an AES core that does one
// round per cycle, so the core keeps up with the byte rate. The first MAC beat
// is valid once the final block, after any held full block, clears the core.
// Reset clears all control state and the configuration registers.
// When the master side stalls, the MAC waits in the output register, the
// AES core holds its next finished MAC, the two-entry job queue fills, and
// then s_axis_tready drops.
// ----------------------------------------------------------------------------
module two_key_cbc_mac_aes128_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // data_byte
    input  wire logic                               s_axis_tuser,  // has_byte
    input  wire logic                               s_axis_tlast,  // end_of_message
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [63:0]                             m_axis_tdata,  // mac_half
    output logic                                    m_axis_tlast,  // last_half
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cbcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [63:0]                        cfg_data
);
    import cbcm_pkg::*;

    logic [63:0] cfg_reg [6];
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    cbcm_job_t   push_job;
    cbcm_job_t   head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY1_HI:  cfg_reg[0] <= cfg_data;
                REG_KEY1_LO:  cfg_reg[1] <= cfg_data;
                REG_KEY2_HI:  cfg_reg[2] <= cfg_data;
                REG_KEY2_LO:  cfg_reg[3] <= cfg_data;
                REG_CHAIN_HI: cfg_reg[4] <= cfg_data;
                REG_CHAIN_LO: cfg_reg[5] <= cfg_data;
                default:      ;
            endcase
        end
    end

    cbcm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .data_byte      (s_axis_tdata),
        .has_byte       (s_axis_tuser),
        .end_of_message (s_axis_tlast),
        .push           (push),
        .push_job       (push_job),
        .q_full         (q_full)
    );

    cbcm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    cbcm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .job         (head),
        .pop         (pop),
        .key_one     ({cfg_reg[0], cfg_reg[1]}),
        .key_two     ({cfg_reg[2], cfg_reg[3]}),
        .start_chain ({cfg_reg[4], cfg_reg[5]}),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .mac_half    (m_axis_tdata),
        .last_half   (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream bench for the two-key AES-128 CBC-MAC unit.
// ----------------------------------------------------------------------------
// An initial block queues message beats and config phases. A driver feeds the
// slave stream with random gaps, a monitor checks each MAC beat against a
// behavioral AES CBC-MAC kept inside the bench, and a watchdog ends a stuck
// run.
// ----------------------------------------------------------------------------
module tb_top;
    import cbcm_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } beat_t;

    typedef struct packed {
        logic [63:0] mac_half;
        logic        last_half;
    } mac_beat_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;

    beat_t       pending_beats[$];
    mac_beat_t   expected_macs[$];
    logic [63:0] mac_regs[6];
    logic [127:0] chain;
    logic [7:0]  blk[16];
    int          blk_count;
    bit          msg_open;
    int          error_count;
    int          idle_cycles;
    bit          calm;
    bit          hold_off;
    bit          src_idle;
    logic        s_axis_tready_q;

    two_key_cbc_mac_aes128_unit u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Byte 0 is the most significant byte of every 128-bit value here.
    function automatic logic [7:0] sb(input logic [7:0] v);
        return SBOX[v];
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] pt);
        logic [7:0]   w[176];
        logic [7:0]   s[16];
        logic [7:0]   t[16];
        logic [7:0]   a0, a1, a2, a3, al, tmp, rc;
        logic [127:0] r;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = key[127 - 8*i -: 8];
            s[i] = pt[127 - 8*i -: 8];
        end
        for (int i = 16; i < 176; i += 4)
        begin
            a0 = w[i-4]; a1 = w[i-3]; a2 = w[i-2]; a3 = w[i-1];
            if (i % 16 == 0)
            begin
                tmp = a0;
                a0 = sb(a1) ^ rc; a1 = sb(a2); a2 = sb(a3); a3 = sb(tmp);
                rc = dbl(rc);
            end
            w[i] = w[i-16] ^ a0; w[i+1] = w[i-15] ^ a1;
            w[i+2] = w[i-14] ^ a2; w[i+3] = w[i-13] ^ a3;
        end
        for (int i = 0; i < 16; i++)
            s[i] ^= w[i];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    t[q + 4*c] = sb(s[q + 4*((c + q) % 4)]);
            if (rnd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ w[16*rnd + i];
        end
        for (int i = 0; i < 16; i++)
            r[127 - 8*i -: 8] = s[i];
        return r;
    endfunction

    function automatic logic [127:0] pack_block(input int n, input bit pad);
        logic [127:0] b;
        b = '0;
        for (int i = 0; i < n; i++)
            b[127 - 8*i -: 8] = blk[i];
        if (pad && n < 16)
            b[127 - 8*n -: 8] = PAD_BYTE;
        return b;
    endfunction

    // Advances the MAC state by one accepted beat and queues any MAC halves.
    task automatic predict_mac(input beat_t b);
        mac_beat_t m;
        if (!b.has_byte && !b.end_of_message)
            return;
        if (!msg_open)
        begin
            chain = {mac_regs[REG_CHAIN_HI], mac_regs[REG_CHAIN_LO]};
            blk_count = 0;
            msg_open = 1'b1;
        end
        if (b.has_byte)
        begin
            if (blk_count == 16)
            begin
                chain = aes_encrypt({mac_regs[REG_KEY1_HI], mac_regs[REG_KEY1_LO]},
                                    chain ^ pack_block(16, 1'b0));
                blk_count = 0;
            end
            blk[blk_count] = b.data_byte;
            blk_count++;
        end
        if (b.end_of_message)
        begin
            chain = aes_encrypt({mac_regs[REG_KEY2_HI], mac_regs[REG_KEY2_LO]},
                                chain ^ pack_block(blk_count, 1'b1));
            blk_count = 0;
            msg_open = 1'b0;
            m.mac_half = chain[127:64]; m.last_half = 1'b0;
            expected_macs.push_back(m);
            m.mac_half = chain[63:0]; m.last_half = 1'b1;
            expected_macs.push_back(m);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mac_regs[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input int mode);
        logic [63:0] v;
        for (int i = 0; i < 6; i++)
        begin
            case (mode)
                0: v = '0;
                1: v = '1;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(i[CFG_IDX_W-1:0], v);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || expected_macs.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic queue_message(input int len, input bit end_alone);
        beat_t b;
        for (int i = 0; i < len; i++)
        begin
            b.data_byte = 8'($urandom);
            b.has_byte = 1'b1;
            b.end_of_message = (i == len - 1) && !end_alone;
            pending_beats.push_back(b);
            if ($urandom_range(0, 19) == 0)
                pending_beats.push_back('{8'($urandom), 1'b0, 1'b0});
        end
        if (end_alone || len == 0)
            pending_beats.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    task automatic random_messages(input int beats);
        int n;
        int len;
        n = 0;
        while (n < beats)
        begin
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 16 * $urandom_range(1, 3);
                2: len = $urandom_range(33, 64);
                default: len = $urandom_range(1, 20);
            endcase
            queue_message(len, $urandom_range(0, 3) == 0);
            n += len + 1;
        end
    endtask

    // Source side.
    always @(negedge clk)
    begin
        if (rst_n && !hold_off && (!s_axis_tvalid || s_axis_tready_q))
        begin
            if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 17))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_beats[0].data_byte;
                s_axis_tuser  <= pending_beats[0].has_byte;
                s_axis_tlast  <= pending_beats[0].end_of_message;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= src_idle ? 1'b0 : (calm || $urandom_range(0, 99) >= 17);
    end

    // Acceptance of the source beat at the rising edge.
    always @(posedge clk)
    begin
        s_axis_tready_q = s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            predict_mac(pending_beats.pop_front());
    end

    // Result side.
    always @(posedge clk)
    begin
        mac_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_macs.size() == 0)
            begin
                report_mismatch("unexpected beat", m_axis_tdata, '0);
            end
            else
            begin
                want = expected_macs.pop_front();
                if (m_axis_tdata !== want.mac_half)
                    report_mismatch("mac_half", m_axis_tdata, want.mac_half);
                if (m_axis_tlast !== want.last_half)
                    report_mismatch("last_half", 64'(m_axis_tlast), 64'(want.last_half));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_valid)
            idle_cycles <= 0;
        else if (pending_beats.size() != 0 || expected_macs.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("two_key_cbc_mac_aes128_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_axis_tready_q = 1'b0;
        error_count = 0; idle_cycles = 0; calm = 1'b0; hold_off = 1'b0; src_idle = 1'b0;
        msg_open = 1'b0; blk_count = 0; chain = '0;
        for (int i = 0; i < 6; i++)
            mac_regs[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: all-zero registers, empty message, edge byte values,
        // exact and partial blocks, end beat without a byte.
        pending_beats.push_back('{8'h00, 1'b0, 1'b0});
        pending_beats.push_back('{8'h00, 1'b0, 1'b1});
        pending_beats.push_back('{8'hff, 1'b1, 1'b1});
        pending_beats.push_back('{8'h00, 1'b1, 1'b1});
        wait_drained();
        write_all_regs(1);
        for (int i = 0; i < 16; i++)
            pending_beats.push_back('{i[0] ? 8'hff : 8'h00, 1'b1, i == 15});
        queue_message(16, 1'b1);
        wait_drained();

        write_all_regs(2);
        calm = 1'b1;
        random_messages(300);
        wait_drained();
        calm = 1'b0;

        // Receiver holds off while the sender keeps offering beats.
        src_idle = 1'b1;
        random_messages(200);
        repeat (600) @(posedge clk);
        src_idle = 1'b0;
        wait_drained();

        write_all_regs(0);
        random_messages(300);
        wait_drained();
        for (int p = 0; p < 4; p++)
        begin
            write_all_regs(2);
            random_messages(250);
            wait_drained();
        end

        if (error_count == 0)
            $display("two_key_cbc_mac_aes128_unit verification clean");
        else
            $display("two_key_cbc_mac_aes128_unit verification failed");
        $finish;
    end
endmodule
